// ===== design/pgs_pkg.sv =====
package pgs_pkg;

  localparam int ROW_W      = 4;
  localparam int COL_W      = 4;
  localparam int WEIGHT_W   = 8;
  localparam int SUM_W      = 12;
  localparam int RND_W      = 31;
  localparam int STATE_W    = 64;
  localparam int NODE_W     = 6;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_NODES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_NODES = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic [STATE_W-1:0]  node_states;
    logic [RND_W-1:0]    random_value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              bit_value;
    logic [ROW_W-1:0]  row_used;
    logic [COL_W-1:0]  column_chosen;
    logic              last;
  } out_item_t;

endpackage

// ===== design/pgs_mem.sv =====
module pgs_mem #(
  parameter int AddrW = 8,
  parameter int DataW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [DataW-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [DataW-1:0] rd_data
);

  localparam int Depth = 1 << AddrW;

  logic [DataW-1:0] mem_r [Depth];
  logic [Depth-1:0] vld_r;
  logic [DataW-1:0] rd_data_r;
  logic             rd_vld_r;

  // Storage array, no reset; entries never written read as zero via the valid bits.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== design/pgs_mod.sv =====
module pgs_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pgs_pkg::RND_W-1:0]  dividend,
  input  logic [pgs_pkg::SUM_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [pgs_pkg::SUM_W-1:0]  remainder
);

  localparam int DvdW = pgs_pkg::RND_W + 1;
  localparam int RemW = pgs_pkg::SUM_W;

  logic            busy_r;
  logic            done_r;
  logic [3:0]      cnt_r;
  logic [DvdW-1:0] dvd_r;
  logic [RemW-1:0] rem_r;
  logic [RemW-1:0] dsr_r;
  logic [RemW:0]   t1;
  logic [RemW:0]   t2;
  logic [RemW-1:0] rem_nxt;

  // Two restoring steps per cycle.
  always_comb begin
    t1 = {rem_r, dvd_r[DvdW-1]};
    if (t1 >= {1'b0, dsr_r}) begin
      t1 = t1 - {1'b0, dsr_r};
    end
    t2 = {t1[RemW-1:0], dvd_r[DvdW-2]};
    if (t2 >= {1'b0, dsr_r}) begin
      t2 = t2 - {1'b0, dsr_r};
    end
    rem_nxt = t2[RemW-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {1'b0, dividend};
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DvdW-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'hF) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== design/probabilistic_gate_sampler_unit.sv =====
// Probabilistic logic gate with a 16 x 16 table of 8-bit weights and a running
// sum per row, both held in synchronous memories with one write and one read
// port. A write request (opcode OP_WRITE) reads the old weight and row sum,
// then writes back the new weight and the adjusted sum before the next request
// can be taken. A step request gathers one bit per configured input node to
// form the row, reads that row's sum, draws r = 1 + random_value mod (sum - 1)
// in a radix-4 remainder unit (skipped when the sum is 0 or 1), then walks the
// row one column per cycle through the weight memory, and finally emits one
// result per output wire, one per cycle while the receiver keeps up, wire 0
// first with last set on the final wire. The block works on one request at a
// time; a finished result waits in the output register while the next request
// is accepted. Memory contents are zero after reset through per-entry valid
// bits, so no clearing pass is needed. Configuration writes are always taken
// and should only be made while idle.
module probabilistic_gate_sampler_unit #(
  parameter int NODE_COUNT = 64,
  parameter int MAX_WIRES  = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pgs_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pgs_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RowW = pgs_pkg::ROW_W;
  localparam int ColW = pgs_pkg::COL_W;
  localparam int SumW = pgs_pkg::SUM_W;
  localparam int WgtW = pgs_pkg::WEIGHT_W;
  localparam int CntW = pgs_pkg::COUNT_W;
  localparam int NodeW = pgs_pkg::NODE_W;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WR   = 7'b0000010,
    S_ROW  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_WALK = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  // Reduces a 6-bit node index modulo NODE_COUNT by restoring subtraction.
  function automatic logic [NodeW-1:0] node_mod(input logic [NodeW-1:0] n);
    logic [12:0] rem;
    rem = {7'd0, n};
    for (int j = 5; j >= 0; j--) begin
      if (rem >= 13'(NODE_COUNT << j)) begin
        rem = rem - 13'(NODE_COUNT << j);
      end
    end
    return rem[NodeW-1:0];
  endfunction

  // A count of zero acts as one; counts above the wire limit saturate.
  function automatic logic [CntW-1:0] clamp_count(input logic [CntW-1:0] c);
    logic [CntW-1:0] res;
    res = c;
    if (c == '0) begin
      res = CntW'(1);
    end else if (32'(c) > MAX_WIRES) begin
      res = CntW'(MAX_WIRES);
    end
    return res;
  endfunction

  // Configuration registers.
  logic [CntW-1:0]                    in_cnt_r;
  logic [CntW-1:0]                    out_cnt_r;
  logic [pgs_pkg::CFG_DATA_W-1:0]     in_nodes_r;
  logic [pgs_pkg::CFG_DATA_W-1:0]     out_nodes_r;

  // Sequencer registers.
  state_t             state_r, state_nxt;
  pgs_pkg::in_item_t  item_r, item_nxt;
  logic [RowW-1:0]    row_r, row_nxt;
  logic [ColW-1:0]    col_r, col_nxt;
  logic [SumW-1:0]    r_r, r_nxt;
  logic [1:0]         wire_r, wire_nxt;
  logic               out_valid_r, out_valid_nxt;
  pgs_pkg::out_item_t out_data_r, out_data_nxt;

  // Memory and remainder unit connections.
  logic                  w_we;
  logic [RowW+ColW-1:0]  w_rd_addr;
  logic [WgtW-1:0]       w_q;
  logic                  s_we;
  logic [RowW-1:0]       s_rd_addr;
  logic [SumW-1:0]       s_q;
  logic [SumW-1:0]       s_wdata;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [SumW-1:0]       div_rem;

  logic [CntW-1:0]       nin;
  logic [CntW-1:0]       nout;
  logic [RowW-1:0]       row_comb;
  logic [4:0]            out_node_lsb;

  assign nin  = clamp_count(in_cnt_r);
  assign nout = clamp_count(out_cnt_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes are taken in any cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r    <= CntW'(1);
      out_cnt_r   <= CntW'(1);
      in_nodes_r  <= '0;
      out_nodes_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pgs_pkg::CFG_INPUT_COUNT:  in_cnt_r    <= cfg_data[CntW-1:0];
        pgs_pkg::CFG_OUTPUT_COUNT: out_cnt_r   <= cfg_data[CntW-1:0];
        pgs_pkg::CFG_INPUT_NODES:  in_nodes_r  <= cfg_data;
        pgs_pkg::CFG_OUTPUT_NODES: out_nodes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The row index is built from the gathered input bits, wire 0 ending up as
  // the most significant of the used bits.
  always_comb begin
    row_comb = '0;
    for (int i = 0; i < 4; i++) begin
      if (CntW'(i) < nin) begin
        row_comb = {row_comb[RowW-2:0],
                    item_r.node_states[node_mod(in_nodes_r[i*NodeW +: NodeW])]};
      end
    end
  end

  assign out_node_lsb = 5'(wire_r) * 5'd6;

  // The new row sum replaces the old weight's share with the new weight; it
  // wraps at twelve bits.
  assign s_wdata = s_q - {{(SumW-WgtW){1'b0}}, w_q}
                       + {{(SumW-WgtW){1'b0}}, item_r.weight};

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    r_nxt         = r_r;
    wire_nxt      = wire_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    w_we          = 1'b0;
    s_we          = 1'b0;
    div_start     = 1'b0;
    w_rd_addr     = {row_r, {ColW{1'b0}}};
    s_rd_addr     = row_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Reads for a weight write are issued speculatively on every idle cycle.
        w_rd_addr = {in_data.row, in_data.column};
        s_rd_addr = in_data.row;
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = (in_data.opcode == pgs_pkg::OP_STEP) ? S_ROW : S_WR;
        end
      end
      S_WR: begin
        w_we      = 1'b1;
        s_we      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROW: begin
        row_nxt   = row_comb;
        s_rd_addr = row_comb;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // Column 0 of the row is read here and held through the division.
        col_nxt = '0;
        if (s_q > SumW'(1)) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          r_nxt     = SumW'(1);
          state_nxt = S_WALK;
        end
      end
      S_DIV: begin
        if (div_done) begin
          r_nxt     = div_rem + SumW'(1);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if ((col_r != {ColW{1'b1}}) && (r_r > {{(SumW-WgtW){1'b0}}, w_q})) begin
          r_nxt   = r_r - {{(SumW-WgtW){1'b0}}, w_q};
          col_nxt = col_r + ColW'(1);
        end else begin
          wire_nxt  = '0;
          state_nxt = S_EMIT;
        end
        w_rd_addr = {row_r, col_nxt};
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.node          = node_mod(out_nodes_r[out_node_lsb +: NodeW]);
          out_data_nxt.bit_value     = col_r[wire_r];
          out_data_nxt.row_used      = row_r;
          out_data_nxt.column_chosen = col_r;
          out_data_nxt.last          = ({1'b0, wire_r} == (nout - CntW'(1)));
          if ({1'b0, wire_r} == (nout - CntW'(1))) begin
            state_nxt = S_IDLE;
          end else begin
            wire_nxt = wire_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    r_r        <= r_nxt;
    wire_r     <= wire_nxt;
    out_data_r <= out_data_nxt;
  end

  // Weight table, addressed row then column.
  pgs_mem #(
    .AddrW(RowW + ColW),
    .DataW(WgtW)
  ) u_weights (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (w_we),
    .wr_addr ({item_r.row, item_r.column}),
    .wr_data (item_r.weight),
    .rd_addr (w_rd_addr),
    .rd_data (w_q)
  );

  // Row sums.
  pgs_mem #(
    .AddrW(RowW),
    .DataW(SumW)
  ) u_sums (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s_we),
    .wr_addr (item_r.row),
    .wr_data (s_wdata),
    .rd_addr (s_rd_addr),
    .rd_data (s_q)
  );

  // Remainder of the random value by the row sum less one.
  pgs_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (item_r.random_value),
    .divisor   (s_q - SumW'(1)),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("remainder unit finished outside the division state");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("remainder unit busy while accepting requests");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the emit state");

  a_row_held_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WALK) && $past(state_r == S_WALK)) |-> $stable(row_r))
    else $error("row changed during the column walk");
`endif

endmodule
